/* design/sensor_block_average_logger_top_defines.svh */
// assertion macros shared by the averaging logger modules
// no dependencies; assumes a clock named clk and a reset named arst_n in scope
`ifndef SENSOR_BLOCK_AVERAGE_LOGGER_TOP_DEFINES_SVH
`define SENSOR_BLOCK_AVERAGE_LOGGER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold on every clock edge out of reset
`define SBAL_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define SBAL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SBAL_ASSERT(lbl, expr, msg)
`define SBAL_ASSERT_IMPL(lbl, ante, cons, msg)
`define SBAL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/sbal_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the averaging logger
// no dependencies
package sbal_pkg;

	// configuration limits
	localparam logic [6:0] MAX_SAMPLES = 7'd90;
	localparam logic [6:0] SPA_RESET   = 7'd60;

	// command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// history record layout
	localparam int REC_W    = 60;
	localparam int TIME_LSB = 0;
	localparam int P_LSB    = 12;
	localparam int TB_LSB   = 24;
	localparam int TA_LSB   = 32;
	localparam int H_LSB    = 48;
	localparam int SPARE_W  = 4;
	localparam logic [REC_W-1:0] REC_ERASED = '1;

	// shared divider geometry
	localparam int DIV_W     = 24;
	localparam int DIVISOR_W = 7;
	localparam int DIV_RADIX = 4;
	localparam int DIV_STEPS = DIV_W / DIV_RADIX;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

endpackage

/* design/sbal_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module sbal_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/sbal_div.sv */
`timescale 1ns / 1ps
// iterative unsigned divider, several quotient bits per cycle
// depends on sbal_pkg and the shared assertion macros
`include "sensor_block_average_logger_top_defines.svh"
module sbal_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbal_pkg::div_req_t       req,
	output logic [sbal_pkg::DIV_W-1:0] quotient,
	output logic                     done
);
	import sbal_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIV_W-1:0]     num_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;

	logic [DIVISOR_W-1:0] rem_nxt;
	logic [DIV_W-1:0]     num_nxt;
	logic [DIV_RADIX-1:0] qbits;

	// restoring steps: remainder always stays below the divisor
	always_comb begin
		logic [DIVISOR_W:0]   t;
		logic [DIVISOR_W-1:0] r;
		logic [DIV_W-1:0]     n;
		r     = rem_q;
		n     = num_q;
		qbits = '0;
		for (int k = 0; k < DIV_RADIX; k++) begin
			t = {r, n[DIV_W-1]};
			n = {n[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				t = t - {1'b0, dsr_q};
				qbits[DIV_RADIX-1-k] = 1'b1;
			end
			r = t[DIVISOR_W-1:0];
		end
		rem_nxt = r;
		num_nxt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (step_q == STEP_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= req.dividend;
				quo_q  <= '0;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				num_q  <= num_nxt;
				rem_q  <= rem_nxt;
				quo_q  <= {quo_q[DIV_W-DIV_RADIX-1:0], qbits};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	`SBAL_ASSERT_IMPL(a_start_idle, req.start, !busy_q, "divider started while busy")
	`SBAL_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "divider done held longer than one cycle")
	`SBAL_ASSERT_IMPL(a_done_not_busy, done_q, !busy_q, "divider done while still iterating")

endmodule

/* design/sensor_block_average_logger_top.sv */
`timescale 1ns / 1ps
// channel    | direction | handshake            | payload
// input      | in        | in_valid / in_stall  | cmd, pressure, temps, humidity, time, slot
// result     | out       | out_valid / out_stall| readback flag, slot, record, wrap flag
// config     | in        | cfg_valid / cfg_ready| cfg_data (samples per average)
//
// a sample that does not close a block is summed without leaving idle; a read passes through
// the read and emit states; a closing sample runs four divisions one after another
// through the shared divider, 4 quotient bits per cycle, and then moves to the emit state
// history reads as all ones after reset through one valid flag per slot
// the result sits in an output register, so a stalled output does not hold off
// the next request unless that request also produces a result
// depends on sbal_pkg, sbal_div, sbal_ram and the shared assertion macros
`include "sensor_block_average_logger_top_defines.svh"
module sensor_block_average_logger_top #(
	parameter int HISTORY_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [11:0]        pressure,
	input  logic signed [7:0]  temp_board,
	input  logic signed [15:0] temp_air,
	input  logic [7:0]         humidity,
	input  logic [11:0]        time_stamp,
	input  logic [7:0]         read_slot,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_readback,
	output logic [7:0]         slot,
	output logic [11:0]        rec_time,
	output logic [11:0]        avg_pressure,
	output logic signed [7:0]  avg_temp_board,
	output logic signed [15:0] avg_temp_air,
	output logic [7:0]         avg_humidity,
	output logic               ring_wrapped,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);
	import sbal_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [8:0] DEPTH9 = 9'(HISTORY_DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DIV, ST_EMIT} state_t;
	typedef enum logic [1:0] {LN_PRES, LN_BOARD, LN_AIR, LN_HUM} lane_t;

	state_t state_q;
	lane_t  lane_q;

	logic [6:0]  spa_q;
	logic [6:0]  cnt_q;
	logic [18:0] sum_p_q;
	logic [14:0] sum_tb_q;
	logic [22:0] sum_ta_q;
	logic [14:0] sum_h_q;
	logic [AW-1:0] ws_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic        start_q;
	logic        rd_hit_q;

	// pending result
	logic               res_readback_q;
	logic [7:0]         res_slot_q;
	logic [11:0]        res_time_q;
	logic [11:0]        res_p_q;
	logic signed [7:0]  res_tb_q;
	logic signed [15:0] res_ta_q;
	logic [7:0]         res_h_q;
	logic               res_wrap_q;

	// output register
	logic               out_valid_q;
	logic               out_rb_q;
	logic [7:0]         out_slot_q;
	logic [11:0]        out_time_q;
	logic [11:0]        out_p_q;
	logic signed [7:0]  out_tb_q;
	logic signed [15:0] out_ta_q;
	logic [7:0]         out_h_q;
	logic               out_wrap_q;

	logic [18:0] sp_nxt;
	logic [14:0] stb_nxt;
	logic [22:0] sta_nxt;
	logic [14:0] sh_nxt;
	logic [6:0]  cnt_nxt;
	logic [14:0] mag_tb;
	logic [22:0] mag_ta;
	logic        neg;
	logic [DIV_W-1:0] q_signed;

	div_req_t         div_req;
	logic [DIV_W-1:0] div_q;
	logic             div_done;

	logic             in_acc;
	logic             cfg_ok;
	logic             ram_we;
	logic             ram_re;
	logic [REC_W-1:0] ram_wdata;
	logic [REC_W-1:0] ram_rdata;
	logic [REC_W-1:0] rec;
	logic             rd_in_range;
	logic             wrap_now;
	logic             out_load;
	logic             start_nxt;

	assign in_stall  = (state_q != ST_IDLE);
	// configuration waits for a gap in the request stream
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ok    = cfg_valid && cfg_ready && (cfg_data != '0) && (cfg_data <= MAX_SAMPLES);

	assign sp_nxt  = sum_p_q + 19'(pressure);
	assign stb_nxt = sum_tb_q + {{7{temp_board[7]}}, temp_board};
	assign sta_nxt = sum_ta_q + {{7{temp_air[15]}}, temp_air};
	assign sh_nxt  = sum_h_q + 15'(humidity);
	assign cnt_nxt = cnt_q + 7'd1;

	assign mag_tb = sum_tb_q[14] ? (~sum_tb_q + 15'd1) : sum_tb_q;
	assign mag_ta = sum_ta_q[22] ? (~sum_ta_q + 23'd1) : sum_ta_q;

	always_comb begin
		div_req.start   = start_q;
		div_req.divisor = spa_q;
		unique case (lane_q)
			LN_PRES:  div_req.dividend = DIV_W'(sum_p_q);
			LN_BOARD: div_req.dividend = DIV_W'(mag_tb);
			LN_AIR:   div_req.dividend = DIV_W'(mag_ta);
			LN_HUM:   div_req.dividend = DIV_W'(sum_h_q);
		endcase
	end

	// truncation toward zero: divide magnitudes, then restore the sign
	assign neg      = ((lane_q == LN_BOARD) && sum_tb_q[14]) || ((lane_q == LN_AIR) && sum_ta_q[22]);
	assign q_signed = neg ? (~div_q + DIV_W'(1)) : div_q;

	sbal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.quotient (div_q),
		.done     (div_done)
	);

	assign rd_in_range = ({1'b0, read_slot} < DEPTH9);
	assign ram_re      = in_acc && (cmd == CMD_READ);
	assign ram_we      = (state_q == ST_DIV) && div_done && (lane_q == LN_HUM);
	assign ram_wdata   = {{SPARE_W{1'b0}}, div_q[7:0], res_ta_q, res_tb_q, res_p_q, res_time_q};
	assign wrap_now    = (ws_q == AW'(HISTORY_DEPTH - 1));

	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign start_nxt = (in_acc && (cmd == CMD_SAMPLE) && (cnt_nxt >= spa_q)) ||
		((state_q == ST_DIV) && div_done && (lane_q != LN_HUM));

	sbal_ram #(
		.WIDTH (REC_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ws_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (read_slot[AW-1:0]),
		.rdata (ram_rdata)
	);

	// slots never written read back as the erased pattern
	assign rec = rd_hit_q ? ram_rdata : REC_ERASED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lane_q         <= LN_PRES;
			spa_q          <= SPA_RESET;
			cnt_q          <= '0;
			sum_p_q        <= '0;
			sum_tb_q       <= '0;
			sum_ta_q       <= '0;
			sum_h_q        <= '0;
			ws_q           <= '0;
			valid_q        <= '0;
			start_q        <= 1'b0;
			rd_hit_q       <= 1'b0;
			res_readback_q <= 1'b0;
			res_slot_q     <= '0;
			res_time_q     <= '0;
			res_p_q        <= '0;
			res_tb_q       <= '0;
			res_ta_q       <= '0;
			res_h_q        <= '0;
			res_wrap_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			out_rb_q       <= 1'b0;
			out_slot_q     <= '0;
			out_time_q     <= '0;
			out_p_q        <= '0;
			out_tb_q       <= '0;
			out_ta_q       <= '0;
			out_h_q        <= '0;
			out_wrap_q     <= 1'b0;
		end else begin
			start_q <= start_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_rb_q    <= res_readback_q;
				out_slot_q  <= res_slot_q;
				out_time_q  <= res_time_q;
				out_p_q     <= res_p_q;
				out_tb_q    <= res_tb_q;
				out_ta_q    <= res_ta_q;
				out_h_q     <= res_h_q;
				out_wrap_q  <= res_wrap_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_ok) begin
						spa_q    <= cfg_data;
						cnt_q    <= '0;
						sum_p_q  <= '0;
						sum_tb_q <= '0;
						sum_ta_q <= '0;
						sum_h_q  <= '0;
					end else if (in_acc) begin
						if (cmd == CMD_READ) begin
							rd_hit_q       <= rd_in_range && valid_q[read_slot[AW-1:0]];
							res_readback_q <= 1'b1;
							res_slot_q     <= read_slot;
							res_wrap_q     <= 1'b0;
							state_q        <= ST_READ;
						end else begin
							sum_p_q    <= sp_nxt;
							sum_tb_q   <= stb_nxt;
							sum_ta_q   <= sta_nxt;
							sum_h_q    <= sh_nxt;
							res_time_q <= time_stamp;
							if (cnt_nxt >= spa_q) begin
								cnt_q   <= '0;
								lane_q  <= LN_PRES;
								state_q <= ST_DIV;
							end else begin
								cnt_q <= cnt_nxt;
							end
						end
					end
				end
				ST_READ: begin
					res_time_q <= rec[TIME_LSB +: 12];
					res_p_q    <= rec[P_LSB +: 12];
					res_tb_q   <= $signed(rec[TB_LSB +: 8]);
					res_ta_q   <= $signed(rec[TA_LSB +: 16]);
					res_h_q    <= rec[H_LSB +: 8];
					state_q    <= ST_EMIT;
				end
				ST_DIV: begin
					if (div_done) begin
						unique case (lane_q)
							LN_PRES:  res_p_q  <= q_signed[11:0];
							LN_BOARD: res_tb_q <= $signed(q_signed[7:0]);
							LN_AIR:   res_ta_q <= $signed(q_signed[15:0]);
							LN_HUM:   res_h_q  <= q_signed[7:0];
						endcase
						if (lane_q == LN_HUM) begin
							valid_q[ws_q]  <= 1'b1;
							ws_q           <= wrap_now ? '0 : ws_q + AW'(1);
							res_readback_q <= 1'b0;
							res_slot_q     <= 8'(ws_q);
							res_wrap_q     <= wrap_now;
							sum_p_q        <= '0;
							sum_tb_q       <= '0;
							sum_ta_q       <= '0;
							sum_h_q        <= '0;
							state_q        <= ST_EMIT;
						end else begin
							lane_q <= lane_t'(lane_q + 2'd1);
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign is_readback    = out_rb_q;
	assign slot           = out_slot_q;
	assign rec_time       = out_time_q;
	assign avg_pressure   = out_p_q;
	assign avg_temp_board = out_tb_q;
	assign avg_temp_air   = out_ta_q;
	assign avg_humidity   = out_h_q;
	assign ring_wrapped   = out_wrap_q;

	`SBAL_ASSERT(a_cnt_below_spa, cnt_q < spa_q, "sample count reached block length")
	`SBAL_ASSERT(a_spa_range, (spa_q != '0) && (spa_q <= MAX_SAMPLES), "block length out of range")
	`SBAL_ASSERT_IMPL(a_done_in_div, div_done, state_q == ST_DIV, "division finished outside averaging")
	`SBAL_ASSERT(a_ram_one_port, !(ram_we && ram_re), "history read and write in one cycle")
	`SBAL_ASSERT_NEXT(a_emit_loads, (state_q == ST_EMIT) && !out_valid_q, out_valid_q && (state_q == ST_IDLE), "pending result not moved to free output")

endmodule

/* tb/tb_sensor_block_average_logger_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the block-average sensor logger: directed table, then random phases
// checks each result against a predictor of sums, averages and ring history, or a table value
// depends on sbal_pkg and sensor_block_average_logger_top
module tb_sensor_block_average_logger_top;
	import sbal_pkg::*;

	localparam int RING_DEPTH = 32;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int RANDOM_ITEMS = 1000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic              cmd;
		logic [11:0]       pressure;
		logic signed [7:0] temp_board;
		logic signed [15:0] temp_air;
		logic [7:0]        humidity;
		logic [11:0]       time_stamp;
		logic [7:0]        read_slot;
	} sample_set_t;

	typedef struct packed {
		logic               is_readback;
		logic [7:0]         slot;
		logic [11:0]        rec_time;
		logic [11:0]        avg_pressure;
		logic signed [7:0]  avg_temp_board;
		logic signed [15:0] avg_temp_air;
		logic [7:0]         avg_humidity;
		logic               ring_wrapped;
	} log_record_t;

	typedef enum {ROW_ITEM, ROW_SETTING} row_kind_t;
	typedef enum {FLOW_FREE, FLOW_RANDOM, FLOW_CHOKED} flow_mode_t;

	typedef struct {
		row_kind_t   kind;
		sample_set_t item;
		logic [6:0]  setting;
		bit          typed;
		log_record_t want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [11:0]        pressure;
	logic signed [7:0]  temp_board;
	logic signed [15:0] temp_air;
	logic [7:0]         humidity;
	logic [11:0]        time_stamp;
	logic [7:0]         read_slot;
	logic               out_valid;
	logic               out_stall;
	logic               is_readback;
	logic [7:0]         slot;
	logic [11:0]        rec_time;
	logic [11:0]        avg_pressure;
	logic signed [7:0]  avg_temp_board;
	logic signed [15:0] avg_temp_air;
	logic [7:0]         avg_humidity;
	logic               ring_wrapped;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [6:0]         cfg_data;

	// predictor state
	logic [6:0]        spa;
	logic [18:0]       acc_pressure;
	int                acc_board;
	int                acc_air;
	logic [14:0]       acc_humidity;
	logic [6:0]        acc_count;
	int unsigned       next_slot;
	logic [REC_W-1:0]  ring [RING_DEPTH];

	log_record_t pending_records[$];
	plan_row_t   plan[$];
	log_record_t got_rec;
	log_record_t want_rec;
	int          errors;
	int          burst_left;

	sensor_block_average_logger_top #(.HISTORY_DEPTH(RING_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .pressure(pressure),
		.temp_board(temp_board), .temp_air(temp_air), .humidity(humidity),
		.time_stamp(time_stamp), .read_slot(read_slot),
		.out_valid(out_valid), .out_stall(out_stall), .is_readback(is_readback),
		.slot(slot), .rec_time(rec_time), .avg_pressure(avg_pressure),
		.avg_temp_board(avg_temp_board), .avg_temp_air(avg_temp_air),
		.avg_humidity(avg_humidity), .ring_wrapped(ring_wrapped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void clear_sums();
		acc_pressure = '0;
		acc_board = 0;
		acc_air = 0;
		acc_humidity = '0;
		acc_count = '0;
	endfunction

	function automatic void apply_setting(logic [6:0] v);
		// out of range writes are dropped and keep the running block
		if (v >= 7'd1 && v <= MAX_SAMPLES) begin
			spa = v;
			clear_sums();
		end
	endfunction

	function automatic bit predict_average(input sample_set_t s, output log_record_t r);
		logic [REC_W-1:0] rec;
		int n;
		int unsigned ws;
		r = '0;
		if (s.cmd == CMD_READ) begin
			rec = (s.read_slot < RING_DEPTH) ? ring[s.read_slot[RING_AW-1:0]] : REC_ERASED;
			r.is_readback = 1'b1;
			r.slot = s.read_slot;
			r.rec_time = rec[TIME_LSB +: 12];
			r.avg_pressure = rec[P_LSB +: 12];
			r.avg_temp_board = rec[TB_LSB +: 8];
			r.avg_temp_air = rec[TA_LSB +: 16];
			r.avg_humidity = rec[H_LSB +: 8];
			return 1'b1;
		end
		acc_pressure = acc_pressure + 19'(s.pressure);
		acc_board = acc_board + int'(s.temp_board);
		acc_air = acc_air + int'(s.temp_air);
		acc_humidity = acc_humidity + 15'(s.humidity);
		acc_count = acc_count + 7'd1;
		if (acc_count < spa)
			return 1'b0;
		n = int'(spa);
		// int division truncates toward zero like the hardware divider
		r.avg_pressure = 12'(acc_pressure / 19'(spa));
		r.avg_temp_board = 8'(acc_board / n);
		r.avg_temp_air = 16'(acc_air / n);
		r.avg_humidity = 8'(acc_humidity / 15'(spa));
		r.rec_time = s.time_stamp;
		ws = (next_slot >= RING_DEPTH) ? 0 : next_slot;
		ring[ws[RING_AW-1:0]] = {4'h0, r.avg_humidity, r.avg_temp_air, r.avg_temp_board,
			r.avg_pressure, r.rec_time};
		next_slot = ws + 1;
		r.ring_wrapped = (next_slot >= RING_DEPTH);
		if (r.ring_wrapped)
			next_slot = 0;
		r.is_readback = 1'b0;
		r.slot = ws[7:0];
		clear_sums();
		return 1'b1;
	endfunction

	function automatic string show(log_record_t r);
		return $sformatf("rb=%0d slot=%0d t=%0d p=%0d tb=%0d ta=%0d h=%0d wrap=%0d",
			r.is_readback, r.slot, r.rec_time, r.avg_pressure, r.avg_temp_board,
			r.avg_temp_air, r.avg_humidity, r.ring_wrapped);
	endfunction

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic sample_set_t mk_sample(logic [11:0] p, logic signed [7:0] tb,
			logic signed [15:0] ta, logic [7:0] h, logic [11:0] t);
		return '{CMD_SAMPLE, p, tb, ta, h, t, 8'($urandom)};
	endfunction

	function automatic sample_set_t mk_read(logic [7:0] s);
		return '{CMD_READ, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
			12'($urandom), s};
	endfunction

	function automatic log_record_t erased_at(logic [7:0] s);
		return '{1'b1, s, 12'd4095, 12'd4095, -8'sd1, -16'sd1, 8'd255, 1'b0};
	endfunction

	function automatic sample_set_t random_set();
		sample_set_t s;
		s.cmd = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_SAMPLE;
		s.pressure = 12'($urandom);
		s.temp_board = 8'($urandom);
		s.temp_air = 16'($urandom);
		s.humidity = 8'($urandom);
		s.time_stamp = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2359));
		s.read_slot = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
		return s;
	endfunction

	// sender, called at a falling edge, returns at a falling edge
	task automatic send_item(input sample_set_t s, input bit typed, input log_record_t want);
		log_record_t r;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 80 : int'($urandom_range(1, 16));
		end
		burst_left--;
		in_valid = 1'b1;
		cmd = s.cmd;
		pressure = s.pressure;
		temp_board = s.temp_board;
		temp_air = s.temp_air;
		humidity = s.humidity;
		time_stamp = s.time_stamp;
		read_slot = s.read_slot;
		do @(posedge clk); while (in_stall);
		if (predict_average(s, r))
			pending_records.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_records.size() != 0) @(negedge clk);
		// a sample that closes no block may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [6:0] v);
		drain();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver stall pattern, independent of the sender
	initial begin
		flow_mode_t mode;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = flow_mode_t'($urandom_range(0, 2));
			repeat ($urandom_range(10, 200)) begin
				@(negedge clk);
				case (mode)
					FLOW_FREE: out_stall = 1'b0;
					FLOW_RANDOM: out_stall = 1'($urandom_range(0, 1));
					default: out_stall = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_rec = '{is_readback, slot, rec_time, avg_pressure, avg_temp_board,
				avg_temp_air, avg_humidity, ring_wrapped};
			if (pending_records.size() == 0) begin
				note_error({"result with nothing expected: ", show(got_rec)});
			end else begin
				want_rec = pending_records.pop_front();
				if (got_rec !== want_rec)
					note_error({"expected ", show(want_rec), " got ", show(got_rec)});
			end
		end
	end

	initial begin
		int sent;
		int phase;
		int phase_len;
		logic [6:0] setting;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_SAMPLE;
		pressure = '0;
		temp_board = '0;
		temp_air = '0;
		humidity = '0;
		time_stamp = '0;
		read_slot = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		burst_left = 0;
		spa = SPA_RESET;
		clear_sums();
		next_slot = 0;
		foreach (ring[i])
			ring[i] = REC_ERASED;

		// erased history, including slots beyond the ring
		plan.push_back('{ROW_ITEM, mk_read(8'd0), 7'd0, 1'b1, erased_at(8'd0)});
		plan.push_back('{ROW_ITEM, mk_read(8'd31), 7'd0, 1'b1, erased_at(8'd31)});
		plan.push_back('{ROW_ITEM, mk_read(8'd32), 7'd0, 1'b1, erased_at(8'd32)});
		plan.push_back('{ROW_ITEM, mk_read(8'd255), 7'd0, 1'b1, erased_at(8'd255)});
		// one sample per block: extremes pass straight through
		plan.push_back('{ROW_SETTING, '0, 7'd1, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_sample(12'd4095, 8'sd127, 16'sd32767, 8'd255, 12'd2359),
			7'd0, 1'b1, '{1'b0, 8'd0, 12'd2359, 12'd4095, 8'sd127, 16'sd32767, 8'd255, 1'b0}});
		plan.push_back('{ROW_ITEM, mk_sample(12'd0, -8'sd128, -16'sd32768, 8'd0, 12'd0),
			7'd0, 1'b1, '{1'b0, 8'd1, 12'd0, 12'd0, -8'sd128, -16'sd32768, 8'd0, 1'b0}});
		plan.push_back('{ROW_ITEM, mk_sample(12'd2048, 8'sd5, -16'sd7, 8'd100, 12'd4095),
			7'd0, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_read(8'd0), 7'd0, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_read(8'd1), 7'd0, 1'b0, '0});
		// out of range settings are dropped
		plan.push_back('{ROW_SETTING, '0, 7'd0, 1'b0, '0});
		plan.push_back('{ROW_SETTING, '0, 7'd127, 1'b0, '0});
		plan.push_back('{ROW_SETTING, '0, 7'd91, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_sample(12'd17, -8'sd3, 16'sd300, 8'd45, 12'd1200),
			7'd0, 1'b0, '0});
		// negative averages truncate toward zero, a read mid-block keeps the sums
		plan.push_back('{ROW_SETTING, '0, 7'd2, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_sample(12'd1, -8'sd1, -16'sd3, 8'd1, 12'd59),
			7'd0, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_read(8'd3), 7'd0, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_sample(12'd0, 8'sd0, 16'sd0, 8'd0, 12'd100),
			7'd0, 1'b0, '0});
		plan.push_back('{ROW_SETTING, '0, 7'd3, 1'b0, '0});
		repeat (3)
			plan.push_back('{ROW_ITEM, mk_sample(12'd4095, -8'sd128, -16'sd32768, 8'd255,
				12'd2359), 7'd0, 1'b0, '0});
		plan.push_back('{ROW_ITEM, mk_read(8'd5), 7'd0, 1'b0, '0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETTING)
				configure(plan[i].setting);
			else
				send_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase == 0)
				setting = MAX_SAMPLES;
			else if (phase == 1)
				setting = 7'd1;
			else if ($urandom_range(0, 3) == 0)
				setting = 7'($urandom_range(1, 90));
			else
				setting = 7'($urandom_range(1, 6));
			if ($urandom_range(0, 3) == 0)
				configure(($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(91, 127)));
			configure(setting);
			phase_len = (setting > 30) ? 200 : int'($urandom_range(40, 120));
			repeat (phase_len) begin
				send_item(random_set(), 1'b0, '0);
				sent++;
				// hold off until everything in flight has come back
				if ($urandom_range(0, 149) == 0)
					drain();
			end
			phase++;
		end

		drain();
		if (errors == 0 && pending_records.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
